// ===== rtl/page_replacement_fifo_lru_assert.svh =====
// Assertion macros for the page replacement block.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef PAGE_REPLACEMENT_FIFO_LRU_ASSERT_SVH
`define PAGE_REPLACEMENT_FIFO_LRU_ASSERT_SVH

// check a property on every clock edge outside reset
`define PRL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition implies another in the next cycle
`define PRL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/prl_pkg.sv =====
// Package for the page replacement block: widths, register indexes, policy codes
// and the control struct that drives each frame cell. No dependencies.
package prl_pkg;

    localparam int PAGES      = 256;
    localparam int PAGE_W     = 8;
    localparam int CFG_W      = 5;
    localparam int CNT_W      = 32;
    localparam int FRAMES_DEF = 16;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 5'd4;

    localparam logic REG_POLICY_MODE = 1'b0;
    localparam logic REG_FRAME_COUNT = 1'b1;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    typedef struct packed {
        logic valid;
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

// ===== rtl/prl_cell.sv =====
// One frame cell of the ordered frame list: holds a page number, compares it
// with the accessed page, and loads a new page or its neighbor's page. Uses prl_pkg.
module prl_cell
    import prl_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [PAGE_W-1:0] in_page,
    input  logic [PAGE_W-1:0] next_page,
    output logic [PAGE_W-1:0] page,
    output logic              match
);

    logic [PAGE_W-1:0] page_reg;
    logic [PAGE_W-1:0] page_next;

    always_comb
    begin
        page_next = page_reg;
        if (ctrl.load)
        begin
            page_next = in_page;
        end
        else if (ctrl.shift)
        begin
            page_next = next_page;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    assign page  = page_reg;
    assign match = ctrl.valid && (page_reg == in_page);

endmodule

// ===== rtl/page_replacement_fifo_lru.sv =====
// Top level of the page replacement block: configuration registers, fill count,
// fault counter, result register and the chain of prl_cell frames. Uses prl_pkg.
//
// Usage: one page number per input item on in_valid/in_ready; one result item
// per access on out_valid/out_ready carrying page_fault, evict_valid,
// evicted_page (zero without an eviction) and fault_total (saturating).
// The frame list is a row of cells, oldest page at cell 0. Every cell compares
// its page with the access at once; the list then shifts toward the head from
// the hit position (LRU hit) or from cell 0 (eviction) and the tail takes the page.
// The result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle unless stalled, from one compare-and-shift step of
// the cell chain; each item depends on the list left by the one before.
// When the receiver stalls, the result holds and in_ready drops until it is taken.
// Reset empties the list, clears the fault count, sets FIFO policy and four
// frames. Configuration writes on cfg_we take effect at once; write while idle.
`include "page_replacement_fifo_lru_assert.svh"

module page_replacement_fifo_lru
    import prl_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [PAGE_W-1:0] page_number,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              page_fault,
    output logic              evict_valid,
    output logic [PAGE_W-1:0] evicted_page,
    output logic [CNT_W-1:0]  fault_total
);

    localparam int FILL_W = $clog2(FRAMES + 1);
    localparam int POS_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

    logic              policy_mode_reg;
    logic [CFG_W-1:0]  frame_count_reg;
    logic [FILL_W-1:0] filled_reg;
    logic [FILL_W-1:0] filled_next;
    logic [CNT_W-1:0]  fault_counter_reg;
    logic [CNT_W-1:0]  fault_counter_next;
    logic              out_valid_reg;
    logic              page_fault_reg;
    logic              evict_valid_reg;
    logic [PAGE_W-1:0] evicted_page_reg;

    logic              accept;
    logic [PAGE_W-1:0] page;
    logic [FRAMES-1:0] match;
    logic [PAGE_W-1:0] cell_page [FRAMES];
    cell_ctrl_t        ctrl [FRAMES];
    logic              hit;
    logic [POS_W-1:0]  hit_pos;
    logic [CMP_W-1:0]  in_use;
    logic              miss_append;
    logic              miss_evict;
    logic              lru_move;
    logic [FILL_W-1:0] start_pos;
    logic [FILL_W-1:0] tail;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign page     = PAGE_W'(page_number % PAGES);

    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (match[i])
            begin
                hit_pos = hit_pos | POS_W'(i);
            end
        end
    end

    always_comb
    begin
        if (frame_count_reg == '0)
        begin
            in_use = CMP_W'(1);
        end
        else if (CMP_W'(frame_count_reg) > CMP_W'(FRAMES))
        begin
            in_use = CMP_W'(FRAMES);
        end
        else
        begin
            in_use = CMP_W'(frame_count_reg);
        end
    end

    assign hit         = |match;
    assign miss_append = !hit && (CMP_W'(filled_reg) < in_use);
    assign miss_evict  = !hit && !(CMP_W'(filled_reg) < in_use);
    assign lru_move    = hit && (policy_mode_reg == POLICY_LRU);
    assign start_pos   = miss_evict ? '0 : FILL_W'(hit_pos);
    assign tail        = filled_reg - FILL_W'(1);

    genvar g;
    generate
        for (g = 0; g < FRAMES; g++)
        begin : g_cell
            logic [PAGE_W-1:0] nb_page;

            if (g + 1 < FRAMES)
            begin : g_mid
                assign nb_page = cell_page[g + 1];
            end
            else
            begin : g_last
                assign nb_page = '0;
            end

            always_comb
            begin
                ctrl[g].valid = FILL_W'(g) < filled_reg;
                ctrl[g].shift = accept && (miss_evict || lru_move)
                                && (FILL_W'(g) >= start_pos) && (FILL_W'(g) < tail);
                ctrl[g].load  = accept
                                && ((miss_append && (FILL_W'(g) == filled_reg))
                                    || ((miss_evict || lru_move) && (FILL_W'(g) == tail)));
            end

            prl_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl[g]),
                .in_page   (page),
                .next_page (nb_page),
                .page      (cell_page[g]),
                .match     (match[g])
            );
        end
    endgenerate

    always_comb
    begin
        filled_next        = filled_reg;
        fault_counter_next = fault_counter_reg;
        if (accept && !hit)
        begin
            if (fault_counter_reg != '1)
            begin
                fault_counter_next = fault_counter_reg + CNT_W'(1);
            end
            if (miss_append)
            begin
                filled_next = filled_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_mode_reg   <= POLICY_FIFO;
            frame_count_reg   <= FRAME_COUNT_RST;
            filled_reg        <= '0;
            fault_counter_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_POLICY_MODE: policy_mode_reg <= cfg_data[0];
                    REG_FRAME_COUNT: frame_count_reg <= cfg_data;
                    default:         policy_mode_reg <= policy_mode_reg;
                endcase
            end
            filled_reg        <= filled_next;
            fault_counter_reg <= fault_counter_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_fault_reg   <= !hit;
            evict_valid_reg  <= miss_evict;
            evicted_page_reg <= miss_evict ? cell_page[0] : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign page_fault   = page_fault_reg;
    assign evict_valid  = evict_valid_reg;
    assign evicted_page = evicted_page_reg;
    assign fault_total  = fault_counter_reg;

    `PRL_ASSERT(a_unique_match, $onehot0(match), "page held in more than one frame")
    `PRL_ASSERT(a_evict_fault, !(out_valid && evict_valid) || page_fault, "eviction without fault")
    `PRL_ASSERT_NEXT(a_fill_grow, !(accept && miss_append), $stable(filled_reg), "fill count moved without append")
    `PRL_ASSERT(a_fill_max, CMP_W'(filled_reg) <= CMP_W'(FRAMES), "fill count beyond frames")

endmodule
